// File: rtl/harmonic_spring_gradient_accumulator_defines.svh
// ----------------------------------------------------------------------------
// Harmonic spring gradient accumulator: assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef HARMONIC_SPRING_GRADIENT_ACCUMULATOR_DEFINES_SVH
`define HARMONIC_SPRING_GRADIENT_ACCUMULATOR_DEFINES_SVH

// Check that cons holds in the cycle after ante; also active during reset
`define HSGA_CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("hsga: next-cycle check failed");

// Check that cons holds in the cycle after ante; ignored while in reset
`define HSGA_CHK_RUN(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsga: run-time check failed");

`endif

// File: rtl/hsga_pkg.sv
// ----------------------------------------------------------------------------
// hsga_pkg
// Types and constants shared by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package hsga_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = $clog2(NODES);
    localparam int GRAD_W = 48;
    localparam int TERM_W = GRAD_W + 1;
    localparam int ROW_W  = 3 * GRAD_W;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_STIFFNESS = 1'b0,
        CFG_PLANAR    = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MS_SQ   = 2'd0,
        MS_GRAD = 2'd1,
        MS_ELO  = 2'd2,
        MS_EHI  = 2'd3
    } t_mul_sel;

    typedef enum logic [1:0] {
        AS_A     = 2'd0,
        AS_B     = 2'd1,
        AS_Q     = 2'd2,
        AS_SWEEP = 2'd3
    } t_addr_sel;

    typedef struct packed {
        logic      capture;
        logic      sweep_wr;
        logic      mul_go;
        t_mul_sel  mul_sel;
        logic      acc_add;
        logic      div_start;
        logic      div_src_acc;
        logic      sum_upd;
        logic      term_store;
        logic [1:0] comp;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        logic      plo_save;
        logic      energy_fin;
        logic      out_load;
    } t_dp_ctrl;

    typedef struct packed {
        t_cmd in_cmd;
        logic in_len_zero;
        logic planar;
        logic div_done;
        logic sweep_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: rtl/hsga_div.sv
// ----------------------------------------------------------------------------
// hsga_div
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hsga_div
    import hsga_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_num,
    input  wire logic [31:0] i_den,
    output logic [63:0]      o_quot,
    output logic             o_done
);

    logic [6:0]  r_cnt, n_cnt;
    logic [63:0] r_num, n_num;
    logic [31:0] r_rem, n_rem;
    logic [32:0] trial;
    logic [32:0] diff;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[63]};
        diff  = trial - {1'b0, i_den};
        n_cnt = r_cnt;
        n_num = r_num;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = 7'd64;
            n_num = i_num;
            n_rem = '0;
        end else if (r_cnt != 7'd0) begin
            n_cnt = r_cnt - 7'd1;
            if (trial >= {1'b0, i_den}) begin
                n_rem = diff[31:0];
                n_num = {r_num[62:0], 1'b1};
            end else begin
                n_rem = trial[31:0];
                n_num = {r_num[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
    end

    assign o_quot = r_num;
    assign o_done = (r_cnt == 7'd0);

endmodule

`default_nettype wire

// File: rtl/hsga_ctrl.sv
// ----------------------------------------------------------------------------
// hsga_ctrl
// Command sequencer: drives the datapath step by step for clear, spring
// add, read and no-op commands.
// ----------------------------------------------------------------------------
`default_nettype none

module hsga_ctrl
    import hsga_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_dp_status i_status,
    output t_dp_ctrl        o_ctrl
);

    typedef enum logic [18:0] {
        ST_SWEEP   = 19'h00001,
        ST_IDLE    = 19'h00002,
        ST_SQ_MUL  = 19'h00004,
        ST_SQ_ACC  = 19'h00008,
        ST_SQ_DST  = 19'h00010,
        ST_SQ_DIV  = 19'h00020,
        ST_SUM     = 19'h00040,
        ST_GR_MUL  = 19'h00080,
        ST_GR_DST  = 19'h00100,
        ST_GR_DIV  = 19'h00200,
        ST_GR_TERM = 19'h00400,
        ST_RD_A    = 19'h00800,
        ST_WR_A    = 19'h01000,
        ST_RD_B    = 19'h02000,
        ST_WR_B    = 19'h04000,
        ST_RD_Q    = 19'h08000,
        ST_EN_MUL  = 19'h10000,
        ST_EN_FIN  = 19'h20000,
        ST_DONE    = 19'h40000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_comp, n_comp;
    logic       r_reply, n_reply;
    logic [1:0] last_comp;

    assign last_comp  = i_status.planar ? 2'd1 : 2'd2;
    assign o_in_stall = (r_state != ST_IDLE);

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_comp  = r_comp;
        n_reply = r_reply;
        o_ctrl  = '0;
        o_ctrl.comp = r_comp;
        unique case (r_state)
            ST_SWEEP: begin
                o_ctrl.sweep_wr = 1'b1;
                o_ctrl.addr_sel = AS_SWEEP;
                if (i_status.sweep_last) begin
                    n_state = r_reply ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.capture = 1'b1;
                    n_comp  = 2'd0;
                    n_reply = 1'b1;
                    unique case (i_status.in_cmd)
                        CMD_CLEAR: n_state = ST_SWEEP;
                        CMD_ADD:   n_state = i_status.in_len_zero ? ST_DONE : ST_SQ_MUL;
                        CMD_READ:  n_state = ST_RD_Q;
                        CMD_NOP:   n_state = ST_DONE;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_SQ_MUL: begin
                o_ctrl.mul_go  = 1'b1;
                o_ctrl.mul_sel = MS_SQ;
                n_state = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                o_ctrl.acc_add = 1'b1;
                if (r_comp == 2'd2) begin
                    n_comp  = 2'd0;
                    n_state = ST_SQ_DST;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_DST: begin
                o_ctrl.div_start   = 1'b1;
                o_ctrl.div_src_acc = 1'b1;
                n_state = ST_SQ_DIV;
            end
            ST_SQ_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_ctrl.sum_upd = 1'b1;
                n_state = ST_GR_MUL;
            end
            ST_GR_MUL: begin
                o_ctrl.mul_go  = 1'b1;
                o_ctrl.mul_sel = MS_GRAD;
                n_state = ST_GR_DST;
            end
            ST_GR_DST: begin
                o_ctrl.div_start = 1'b1;
                n_state = ST_GR_DIV;
            end
            ST_GR_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_GR_TERM;
                end
            end
            ST_GR_TERM: begin
                o_ctrl.term_store = 1'b1;
                if (r_comp == last_comp) begin
                    n_state = ST_RD_A;
                end else begin
                    n_comp  = r_comp + 2'd1;
                    n_state = ST_GR_MUL;
                end
            end
            ST_RD_A: begin
                o_ctrl.mem_rd   = 1'b1;
                o_ctrl.addr_sel = AS_A;
                n_state = ST_WR_A;
            end
            ST_WR_A: begin
                o_ctrl.mem_wr   = 1'b1;
                o_ctrl.addr_sel = AS_A;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                o_ctrl.mem_rd   = 1'b1;
                o_ctrl.addr_sel = AS_B;
                n_state = ST_WR_B;
            end
            ST_WR_B: begin
                o_ctrl.mem_wr   = 1'b1;
                o_ctrl.addr_sel = AS_B;
                n_state = ST_DONE;
            end
            ST_RD_Q: begin
                o_ctrl.mem_rd   = 1'b1;
                o_ctrl.addr_sel = AS_Q;
                o_ctrl.mul_go   = 1'b1;
                o_ctrl.mul_sel  = MS_ELO;
                n_state = ST_EN_MUL;
            end
            ST_EN_MUL: begin
                o_ctrl.mul_go   = 1'b1;
                o_ctrl.mul_sel  = MS_EHI;
                o_ctrl.plo_save = 1'b1;
                n_state = ST_EN_FIN;
            end
            ST_EN_FIN: begin
                o_ctrl.energy_fin = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_ctrl.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
            r_comp  <= '0;
            r_reply <= 1'b0;
        end else begin
            r_state <= n_state;
            r_comp  <= n_comp;
            r_reply <= n_reply;
        end
    end

endmodule

`default_nettype wire

// File: rtl/hsga_dp.sv
// ----------------------------------------------------------------------------
// hsga_dp
// Datapath: node gradient memory, shared multiplier, divider, stretch sum,
// energy scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsga_dp
    import hsga_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [9:0]  i_end_a,
    input  wire logic [9:0]  i_end_b,
    input  wire logic [9:0]  i_query_node,
    input  wire logic signed [31:0] i_disp_x,
    input  wire logic signed [31:0] i_disp_y,
    input  wire logic signed [31:0] i_disp_z,
    input  wire logic [31:0] i_contour_len,
    input  wire logic        i_out_stall,
    input  wire t_dp_ctrl    i_ctrl,
    output t_dp_status       o_status,
    output logic             o_out_valid,
    output logic signed [47:0] o_out_grad_x,
    output logic signed [47:0] o_out_grad_y,
    output logic signed [47:0] o_out_grad_z,
    output logic [62:0]      o_energy,
    output logic             o_saturated
);

    localparam logic signed [49:0] SAT_MAX = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT_MIN = -SAT_MAX - 50'sd1;
    localparam logic [63:0]        TERM_CAP = 64'd1 << 47;

    // configuration
    logic [31:0] r_kappa;
    logic        r_planar;

    // captured item
    logic [NODE_W-1:0] r_a, r_b, r_q;
    logic [31:0]       r_len;
    logic [31:0]       r_mag [3];
    logic [2:0]        r_neg;
    logic              r_is_read;

    // arithmetic state
    logic [63:0] r_prod, r_acc, r_plo, r_sum;
    logic signed [TERM_W-1:0] r_term [3];
    logic        r_ovf;
    logic [62:0] r_energy;
    logic        r_eclip;
    logic [NODE_W-1:0] r_sweep;

    // memory
    logic [ROW_W-1:0]  r_mem [NODES];
    logic [ROW_W-1:0]  r_rdata;
    logic [NODE_W-1:0] addr;
    logic [ROW_W-1:0]  wdata;
    logic [ROW_W-1:0]  sat_row;
    logic [2:0]        sat_hit;

    // output register
    logic        r_valid;
    logic signed [47:0] r_gx, r_gy, r_gz;
    logic [62:0] r_oen;
    logic        r_osat;

    logic [31:0] mul_a, mul_b;
    logic [63:0] quot;
    logic        div_done;
    logic [64:0] sum_ext;
    logic [63:0] q_cap;
    logic [47:0] q_mag;
    logic signed [TERM_W-1:0] term_new;
    logic [63:0] en_v;
    logic        en_clip;

    function automatic logic [31:0] mag32(input logic signed [31:0] d);
        logic [31:0] u;
        u = d;
        return d[31] ? (~u + 32'd1) : u;
    endfunction

    // multiplier operand selection
    always_comb begin
        unique case (i_ctrl.mul_sel)
            MS_SQ: begin
                mul_a = r_mag[i_ctrl.comp];
                mul_b = r_mag[i_ctrl.comp];
            end
            MS_GRAD: begin
                mul_a = r_kappa;
                mul_b = r_mag[i_ctrl.comp];
            end
            MS_ELO: begin
                mul_a = r_kappa;
                mul_b = r_sum[31:0];
            end
            MS_EHI: begin
                mul_a = r_kappa;
                mul_b = r_sum[63:32];
            end
            default: begin
                mul_a = r_kappa;
                mul_b = r_sum[31:0];
            end
        endcase
    end

    hsga_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (i_ctrl.div_src_acc ? r_acc : r_prod),
        .i_den   (r_len),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // saturating stretch sum and capped gradient term
    always_comb begin
        sum_ext  = {1'b0, r_sum} + {1'b0, quot};
        q_cap    = (quot > TERM_CAP) ? TERM_CAP : quot;
        q_mag    = q_cap[47:0];
        term_new = r_neg[i_ctrl.comp] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    // energy scaling: (hi << 15) + (lo >> 17), clipped to 63 bits
    always_comb begin
        en_v    = {r_prod[48:0], 15'd0} + {17'd0, r_plo[63:17]};
        en_clip = (r_prod[63:48] != 16'd0) || en_v[63];
    end

    // saturating update of one gradient row; the far end takes the negated term
    always_comb begin
        logic signed [49:0] acc_e;
        logic signed [49:0] trm_e;
        logic signed [49:0] s;
        acc_e = '0;
        trm_e = '0;
        s     = '0;
        for (int c = 0; c < 3; c++) begin
            acc_e = 50'(signed'(r_rdata[c*GRAD_W +: GRAD_W]));
            trm_e = (i_ctrl.addr_sel == AS_B) ? -50'(r_term[c]) : 50'(r_term[c]);
            s     = acc_e + trm_e;
            sat_hit[c] = 1'b0;
            if (s > SAT_MAX) begin
                s = SAT_MAX;
                sat_hit[c] = 1'b1;
            end else if (s < SAT_MIN) begin
                s = SAT_MIN;
                sat_hit[c] = 1'b1;
            end
            sat_row[c*GRAD_W +: GRAD_W] = s[GRAD_W-1:0];
        end
    end

    // memory address and write data
    always_comb begin
        unique case (i_ctrl.addr_sel)
            AS_A:     addr = r_a;
            AS_B:     addr = r_b;
            AS_Q:     addr = r_q;
            AS_SWEEP: addr = r_sweep;
            default:  addr = r_sweep;
        endcase
        wdata = i_ctrl.sweep_wr ? '0 : sat_row;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mem_wr || i_ctrl.sweep_wr) begin
            r_mem[addr] <= wdata;
        end
        if (i_ctrl.mem_rd) begin
            r_rdata <= r_mem[addr];
        end
    end

    // control state: config, sum, flag, sweep counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kappa  <= 32'd65536;
            r_planar <= 1'b0;
            r_sum    <= '0;
            r_ovf    <= 1'b0;
            r_sweep  <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STIFFNESS: r_kappa  <= i_cfg_data;
                    CFG_PLANAR:    r_planar <= i_cfg_data[0];
                    default:       r_planar <= r_planar;
                endcase
            end
            if (i_ctrl.sweep_wr) begin
                r_sweep <= r_sweep + NODE_W'(1);
            end
            if (i_ctrl.capture) begin
                if (t_cmd'(i_cmd) == CMD_CLEAR) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else if (t_cmd'(i_cmd) == CMD_ADD && i_contour_len == 32'd0) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_ctrl.sum_upd) begin
                if (sum_ext[64]) begin
                    r_sum <= '1;
                    r_ovf <= 1'b1;
                end else begin
                    r_sum <= sum_ext[63:0];
                end
            end
            if (i_ctrl.term_store && quot > TERM_CAP) begin
                r_ovf <= 1'b1;
            end
            if (i_ctrl.mem_wr && (sat_hit != 3'b000)) begin
                r_ovf <= 1'b1;
            end
            if (i_ctrl.out_load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_a       <= i_end_a;
            r_b       <= i_end_b;
            r_q       <= i_query_node;
            r_len     <= i_contour_len;
            r_mag[0]  <= mag32(i_disp_x);
            r_mag[1]  <= mag32(i_disp_y);
            r_mag[2]  <= mag32(i_disp_z);
            r_neg     <= {i_disp_z[31], i_disp_y[31], i_disp_x[31]};
            r_is_read <= (t_cmd'(i_cmd) == CMD_READ);
            r_acc     <= '0;
            for (int c = 0; c < 3; c++) begin
                r_term[c] <= '0;
            end
        end
        if (i_ctrl.mul_go) begin
            r_prod <= 64'(mul_a) * 64'(mul_b);
        end
        if (i_ctrl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_ctrl.term_store) begin
            r_term[i_ctrl.comp] <= term_new;
        end
        if (i_ctrl.plo_save) begin
            r_plo <= r_prod;
        end
        if (i_ctrl.energy_fin) begin
            r_energy <= en_clip ? '1 : en_v[62:0];
            r_eclip  <= en_clip;
        end
        if (i_ctrl.out_load) begin
            r_gx   <= r_is_read ? signed'(r_rdata[0*GRAD_W +: GRAD_W]) : '0;
            r_gy   <= r_is_read ? signed'(r_rdata[1*GRAD_W +: GRAD_W]) : '0;
            r_gz   <= r_is_read ? signed'(r_rdata[2*GRAD_W +: GRAD_W]) : '0;
            r_oen  <= r_is_read ? r_energy : '0;
            r_osat <= r_ovf || (r_is_read && r_eclip);
        end
    end

    assign o_status.in_cmd      = t_cmd'(i_cmd);
    assign o_status.in_len_zero = (i_contour_len == 32'd0);
    assign o_status.planar      = r_planar;
    assign o_status.div_done    = div_done;
    assign o_status.sweep_last  = (r_sweep == NODE_W'(NODES - 1));
    assign o_status.out_free    = !r_valid || !i_out_stall;

    assign o_out_valid  = r_valid;
    assign o_out_grad_x = r_gx;
    assign o_out_grad_y = r_gy;
    assign o_out_grad_z = r_gz;
    assign o_energy     = r_oen;
    assign o_saturated  = r_osat;

endmodule

`default_nettype wire

// File: rtl/harmonic_spring_gradient_accumulator.sv
// Spring add time is set by one divide per stretch term and per gradient component, so
//   planar mode, with two gradient components, is shorter.
// Throughput: one item at a time; the next beat is taken once the result sits in the
//   output register, so a waiting result does not hold off the next beat.
// Reset (synchronous, active low) starts a clearing pass over all of node memory;
//   input stays stalled until it ends. Configuration writes are taken throughout.
`default_nettype none

module harmonic_spring_gradient_accumulator
    import hsga_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [9:0]  i_end_a,
    input  wire logic [9:0]  i_end_b,
    input  wire logic [9:0]  i_query_node,
    input  wire logic signed [31:0] i_disp_x,
    input  wire logic signed [31:0] i_disp_y,
    input  wire logic signed [31:0] i_disp_z,
    input  wire logic [31:0] i_contour_len,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic signed [47:0] o_out_grad_x,
    output logic signed [47:0] o_out_grad_y,
    output logic signed [47:0] o_out_grad_z,
    output logic [62:0]      o_energy,
    output logic             o_saturated
);

    t_dp_ctrl   dp_ctrl;
    t_dp_status dp_status;

    hsga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_ctrl     (dp_ctrl)
    );

    hsga_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (i_cmd),
        .i_end_a       (i_end_a),
        .i_end_b       (i_end_b),
        .i_query_node  (i_query_node),
        .i_disp_x      (i_disp_x),
        .i_disp_y      (i_disp_y),
        .i_disp_z      (i_disp_z),
        .i_contour_len (i_contour_len),
        .i_out_stall   (i_out_stall),
        .i_ctrl        (dp_ctrl),
        .o_status      (dp_status),
        .o_out_valid   (o_out_valid),
        .o_out_grad_x  (o_out_grad_x),
        .o_out_grad_y  (o_out_grad_y),
        .o_out_grad_z  (o_out_grad_z),
        .o_energy      (o_energy),
        .o_saturated   (o_saturated)
    );

endmodule

`default_nettype wire

// File: rtl/hsga_checker.sv
// ----------------------------------------------------------------------------
// hsga_checker
// Port-level checks of the accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "harmonic_spring_gradient_accumulator_defines.svh"

module hsga_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [47:0] o_out_grad_x,
    input wire logic [47:0] o_out_grad_y,
    input wire logic [47:0] o_out_grad_z,
    input wire logic [62:0] o_energy,
    input wire logic        o_saturated
);

    // reset starts the clearing pass: no result, input held off
    `HSGA_CHK_NEXT(a_reset_quiet, !i_rst_n, !o_out_valid && o_in_stall)

    // one item at a time: after an accepted beat the input stalls
    `HSGA_CHK_RUN(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)

    // a stalled result stays offered
    `HSGA_CHK_RUN(a_out_hold, o_out_valid && i_out_stall, o_out_valid)

    // a stalled result keeps its payload
    `HSGA_CHK_RUN(a_out_stable, o_out_valid && i_out_stall,
        $stable(o_out_grad_x) && $stable(o_out_grad_y) && $stable(o_out_grad_z)
        && $stable(o_energy) && $stable(o_saturated))

endmodule

bind harmonic_spring_gradient_accumulator hsga_checker u_hsga_checker (.*);

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Harmonic spring gradient accumulator testbench
// Drives clear, spring, read and no-op beats with random idling on both
// channels, predicts every result from a software copy of the gradient store
// and the stretch sum, and checks each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import hsga_pkg::*;

    typedef struct {
        t_cmd               cmd;
        bit [9:0]           end_a;
        bit [9:0]           end_b;
        bit [9:0]           query;
        bit signed [31:0]   dx;
        bit signed [31:0]   dy;
        bit signed [31:0]   dz;
        bit [31:0]          len;
    } spring_beat_t;

    typedef struct {
        bit signed [47:0]   gx;
        bit signed [47:0]   gy;
        bit signed [47:0]   gz;
        bit [62:0]          energy;
        bit                 sat;
    } node_readout_t;

    localparam longint GRAD_HI  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint GRAD_LO  = -GRAD_HI - 1;
    localparam bit [63:0] TERM_LIMIT = 64'd1 << 47;
    localparam bit [63:0] E_LIMIT    = 64'h7FFF_FFFF_FFFF_FFFF;

    // Gradient and energy predictor with its own copy of the node store
    class spring_scoreboard;
        longint         grad_x [NODES];
        longint         grad_y [NODES];
        longint         grad_z [NODES];
        bit [63:0]      stretch;
        bit             ovf;
        bit [31:0]      kappa;
        bit             planar;
        node_readout_t  readout_q [$];
        int             errors;

        function void clear_store();
            foreach (grad_x[i]) begin
                grad_x[i] = 0;
                grad_y[i] = 0;
                grad_z[i] = 0;
            end
            stretch = 0;
            ovf     = 0;
        endfunction

        function longint sat_add(longint acc, longint d);
            longint s;
            s = acc + d;
            if (s > GRAD_HI) begin
                ovf = 1;
                return GRAD_HI;
            end
            if (s < GRAD_LO) begin
                ovf = 1;
                return GRAD_LO;
            end
            return s;
        endfunction

        function void bump(int c, int node, longint t);
            if (c == 0) grad_x[node] = sat_add(grad_x[node], t);
            else if (c == 1) grad_y[node] = sat_add(grad_y[node], t);
            else grad_z[node] = sat_add(grad_z[node], t);
        endfunction

        function void add_spring(spring_beat_t b);
            bit [63:0]  mag [3];
            bit         neg [3];
            bit [63:0]  sq;
            bit [63:0]  inc;
            bit [63:0]  qv;
            bit [63:0]  n64;
            longint     d;
            longint     term;
            int         dims;
            n64 = {32'd0, b.len};
            if (b.len == 0) begin
                ovf = 1;
                return;
            end
            sq = 0;
            for (int c = 0; c < 3; c++) begin
                d = (c == 0) ? longint'(b.dx) : (c == 1) ? longint'(b.dy) : longint'(b.dz);
                neg[c] = d < 0;
                mag[c] = neg[c] ? -d : d;
                sq += mag[c] * mag[c];
            end
            inc = sq / n64;
            if (inc > 64'hFFFF_FFFF_FFFF_FFFF - stretch) begin
                stretch = '1;
                ovf     = 1;
            end else begin
                stretch += inc;
            end
            dims = planar ? 2 : 3;
            for (int c = 0; c < dims; c++) begin
                qv = ({32'd0, kappa} * mag[c]) / n64;
                if (qv > TERM_LIMIT) begin
                    qv  = TERM_LIMIT;
                    ovf = 1;
                end
                term = neg[c] ? -longint'(qv) : longint'(qv);
                bump(c, b.end_a, term);
                bump(c, b.end_b, -term);
            end
        endfunction

        // Work out the result of one accepted input beat
        function void note_input(spring_beat_t b);
            node_readout_t  r;
            bit [63:0]      p_lo;
            bit [63:0]      p_hi;
            bit [63:0]      v;
            bit             clip;
            r    = '{default: 0};
            clip = 0;
            case (b.cmd)
                CMD_CLEAR: clear_store();
                CMD_ADD:   add_spring(b);
                CMD_READ: begin
                    r.gx = 48'(grad_x[b.query]);
                    r.gy = 48'(grad_y[b.query]);
                    r.gz = 48'(grad_z[b.query]);
                    p_lo = (stretch & 64'hFFFF_FFFF) * kappa;
                    p_hi = (stretch >> 32) * kappa;
                    if (p_hi >= (64'd1 << 48)) begin
                        clip = 1;
                        v    = E_LIMIT;
                    end else begin
                        v = (p_hi << 15) + (p_lo >> 17);
                        if (v > E_LIMIT) begin
                            clip = 1;
                            v    = E_LIMIT;
                        end
                    end
                    r.energy = v[62:0];
                end
                default: ;
            endcase
            r.sat = ovf | clip;
            readout_q.push_back(r);
        endfunction

        function void check_result(node_readout_t got);
            node_readout_t e;
            if (readout_q.size() == 0) begin
                $error("result beat with no expectation waiting");
                errors++;
                return;
            end
            e = readout_q.pop_front();
            if (got.gx !== e.gx) begin
                $error("out_grad_x expected %0d actual %0d", e.gx, got.gx);
                errors++;
            end
            if (got.gy !== e.gy) begin
                $error("out_grad_y expected %0d actual %0d", e.gy, got.gy);
                errors++;
            end
            if (got.gz !== e.gz) begin
                $error("out_grad_z expected %0d actual %0d", e.gz, got.gz);
                errors++;
            end
            if (got.energy !== e.energy) begin
                $error("energy expected %0d actual %0d", e.energy, got.energy);
                errors++;
            end
            if (got.sat !== e.sat) begin
                $error("saturated expected %0d actual %0d", e.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_cmd;
    logic [9:0]         i_end_a;
    logic [9:0]         i_end_b;
    logic [9:0]         i_query_node;
    logic signed [31:0] i_disp_x;
    logic signed [31:0] i_disp_y;
    logic signed [31:0] i_disp_z;
    logic [31:0]        i_contour_len;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [47:0] o_out_grad_x;
    logic signed [47:0] o_out_grad_y;
    logic signed [47:0] o_out_grad_z;
    logic [62:0]        o_energy;
    logic               o_saturated;

    spring_scoreboard   sb;
    bit                 hold_req;

    harmonic_spring_gradient_accumulator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_end_a       (i_end_a),
        .i_end_b       (i_end_b),
        .i_query_node  (i_query_node),
        .i_disp_x      (i_disp_x),
        .i_disp_y      (i_disp_y),
        .i_disp_z      (i_disp_z),
        .i_contour_len (i_contour_len),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_grad_x  (o_out_grad_x),
        .o_out_grad_y  (o_out_grad_y),
        .o_out_grad_z  (o_out_grad_z),
        .o_energy      (o_energy),
        .o_saturated   (o_saturated)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Note accepted input beats and check accepted result beats
    always @(posedge i_clk) begin
        spring_beat_t  b;
        node_readout_t r;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            b.cmd   = t_cmd'(i_cmd);
            b.end_a = i_end_a;
            b.end_b = i_end_b;
            b.query = i_query_node;
            b.dx    = i_disp_x;
            b.dy    = i_disp_y;
            b.dz    = i_disp_z;
            b.len   = i_contour_len;
            sb.note_input(b);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            r.gx     = o_out_grad_x;
            r.gy     = o_out_grad_y;
            r.gz     = o_out_grad_z;
            r.energy = o_energy;
            r.sat    = o_saturated;
            sb.check_result(r);
        end
    end

    // Receiver: random stall runs, plus one long hold-off on request
    initial begin
        int  run;
        bit  level;
        int  r;
        run   = 0;
        level = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                if (hold_req) begin
                    level    = 1;
                    run      = 3000;
                    hold_req = 0;
                end else begin
                    r     = $urandom_range(0, 99);
                    level = r < 45;
                    run   = (r < 90) ? $urandom_range(1, 4) : $urandom_range(20, 120);
                end
            end
            i_out_stall <= level;
            run--;
        end
    end

    initial begin
        #200_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    function automatic bit [9:0] pick_node();
        if ($urandom_range(0, 9) < 7) return 10'($urandom_range(0, 7));
        return 10'($urandom);
    endfunction

    function automatic bit [31:0] pick_disp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
        if (r < 85) return $urandom;
        if (r < 90) return 32'h8000_0000;
        if (r < 95) return 32'h7FFF_FFFF;
        return 32'd0;
    endfunction

    function automatic bit [31:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(32'h1000, 32'h10_0000);
        if (r < 80) return $urandom;
        if (r < 88) return $urandom_range(1, 16);
        if (r < 94) return 32'hFFFF_FFFF;
        return 32'd0;
    endfunction

    function automatic spring_beat_t random_beat();
        spring_beat_t b;
        int           r;
        r = $urandom_range(0, 99);
        b.cmd   = (r < 3) ? CMD_CLEAR : (r < 70) ? CMD_ADD : (r < 95) ? CMD_READ : CMD_NOP;
        b.end_a = pick_node();
        b.end_b = ($urandom_range(0, 19) == 0) ? b.end_a : pick_node();
        b.query = pick_node();
        b.dx    = pick_disp();
        b.dy    = pick_disp();
        b.dz    = pick_disp();
        b.len   = pick_len();
        return b;
    endfunction

    function automatic spring_beat_t make_beat(t_cmd c, bit [9:0] a, bit [9:0] e,
                                               bit [9:0] q, bit [31:0] x, bit [31:0] y,
                                               bit [31:0] z, bit [31:0] n);
        spring_beat_t b;
        b = '{cmd: c, end_a: a, end_b: e, query: q, dx: x, dy: y, dz: z, len: n};
        return b;
    endfunction

    // Offer one beat, hold it until taken
    task automatic send_beat(spring_beat_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cmd         <= b.cmd;
        i_end_a       <= b.end_a;
        i_end_b       <= b.end_b;
        i_query_node  <= b.query;
        i_disp_x      <= b.dx;
        i_disp_y      <= b.dy;
        i_disp_z      <= b.dz;
        i_contour_len <= b.len;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.readout_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, bit [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_STIFFNESS) sb.kappa = val;
        else sb.planar = val[0];
    endtask

    initial begin
        bit [31:0] kap_set [7];
        bit        pln_set [7];
        sb = new();
        sb.clear_store();
        sb.kappa    = 32'd65536;
        sb.planar   = 0;
        sb.errors   = 0;
        hold_req    = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_cmd         = '0;
        i_end_a       = '0;
        i_end_b       = '0;
        i_query_node  = '0;
        i_disp_x      = '0;
        i_disp_y      = '0;
        i_disp_z      = '0;
        i_contour_len = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, every command, zero length, shared endpoints
        write_reg(CFG_STIFFNESS, 32'd65536);
        write_reg(CFG_PLANAR, 1'b0);
        send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 32'h10000));
        send_beat(make_beat(CMD_ADD, 0, 1, 0, 32'h10000, 32'hFFFF0000, 32'h8000, 32'h10000));
        send_beat(make_beat(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_READ, 0, 0, 1, 0, 0, 0, 0));
        send_beat(make_beat(CMD_ADD, 1023, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 1));
        send_beat(make_beat(CMD_READ, 0, 0, 1023, 0, 0, 0, 0));
        send_beat(make_beat(CMD_ADD, 5, 6, 0, 32'h1234, 32'h5678, 32'h9ABC, 0));
        send_beat(make_beat(CMD_NOP, 3, 3, 3, '1, '1, '1, '1));
        send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_ADD, 7, 7, 0, 32'h30000, 32'hFFFD0000, 32'h10000, 32'h20000));
        send_beat(make_beat(CMD_READ, 0, 0, 7, 0, 0, 0, 0));
        send_beat(make_beat(CMD_ADD, 2, 3, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'd1));
        send_beat(make_beat(CMD_ADD, 2, 3, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'd1));
        send_beat(make_beat(CMD_READ, 0, 0, 2, 0, 0, 0, 0));
        send_beat(make_beat(CMD_READ, 0, 0, 3, 0, 0, 0, 0));
        send_beat(make_beat(CMD_ADD, 4, 9, 0, 32'h10000, 32'h10000, 32'h10000,
                            32'hFFFF_FFFF));
        send_beat(make_beat(CMD_READ, 0, 0, 9, 0, 0, 0, 0));
        send_beat(make_beat(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_beat(make_beat(CMD_READ, 0, 0, 2, 0, 0, 0, 0));
        drain();

        // Random phases over several register settings, extremes included
        kap_set = '{32'd65536, 32'd0, 32'hFFFF_FFFF, $urandom, $urandom, 32'd65536,
                    32'hFFFF_FFFF};
        pln_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int p = 0; p < 7; p++) begin
            write_reg(CFG_STIFFNESS, kap_set[p]);
            write_reg(CFG_PLANAR, pln_set[p]);
            for (int k = 0; k < 250; k++) begin
                if (p == 2 && k == 20) hold_req = 1;
                if (p == 4 && k == 120) drain();
                send_beat(random_beat());
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (sb.readout_q.size() != 0) begin
            $error("%0d expected results never arrived", sb.readout_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
